// ===== hdl/efr_pkg.sv =====
// Shared types, constants and the CRC byte update for the escaped frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

    localparam logic [7:0]  START_BYTE    = 8'hF1;
    localparam logic [7:0]  ESC_BYTE      = 8'hF2;
    localparam logic [8:0]  LEN_OFFSET    = 9'd6;
    localparam logic [7:0]  WAITING_INDEX = 8'hFF;
    localparam logic [7:0]  LENGTH_POS    = 8'd3;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT_RST  = 16'hFFFF;
    localparam logic [7:0]  MAX_PAY_RST   = 8'hFF;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_INIT    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 8'd1;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_CRC_ERR  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    // Receiver state carried from one byte to the next.
    typedef struct packed {
        logic [7:0]  frame_index;
        logic [7:0]  previous_byte;
        logic [7:0]  length_byte;
        logic [15:0] crc_remainder;
    } efr_state_t;

    // One decoded result, with a flag that says whether the byte produced one.
    typedef struct packed {
        logic       produced;
        logic [7:0] data;
        logic [6:0] position;
        logic       last;
        status_t    status;
    } efr_result_t;

    // CRC-16-CCITT, MSB first, one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  byte_in);
        logic [15:0] crc;
        crc = crc_in ^ {byte_in, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/efr_decode.sv =====
// Per-byte decode: start and escape handling, CRC update, end of frame and status.
`timescale 1ns / 1ps
`default_nettype none

module efr_decode #(
    parameter int BUF_BYTES = 128
) (
    input  wire logic [7:0]          rx_byte,
    input  wire logic [15:0]         crc_init,
    input  wire logic [7:0]          max_payload,
    input  wire efr_pkg::efr_state_t state_cur,
    output efr_pkg::efr_state_t      state_next,
    output efr_pkg::efr_result_t     result
);

    localparam logic [7:0] BUF_LIMIT = 8'(BUF_BYTES);

    logic        is_start;
    logic        is_esc;
    logic        take;
    logic [7:0]  stored;
    logic [7:0]  len_new;
    logic [15:0] crc_new;
    logic [7:0]  idx_inc;
    logic        end_hit;
    logic [7:0]  payload_len;

    assign is_start    = (rx_byte == efr_pkg::START_BYTE);
    assign is_esc      = (rx_byte == efr_pkg::ESC_BYTE);
    assign take        = !is_start && !is_esc && (state_cur.frame_index < BUF_LIMIT);
    assign stored      = (state_cur.previous_byte == efr_pkg::ESC_BYTE) ? ~rx_byte : rx_byte;
    assign len_new     = (state_cur.frame_index == efr_pkg::LENGTH_POS) ? stored
                                                                       : state_cur.length_byte;
    assign crc_new     = efr_pkg::crc16_byte(state_cur.crc_remainder, stored);
    assign idx_inc     = state_cur.frame_index + 8'd1;
    // The end point can reach 261, so the compare is done one bit wider.
    assign end_hit     = ({1'b0, idx_inc} == ({1'b0, len_new} + efr_pkg::LEN_OFFSET));
    assign payload_len = idx_inc - 8'd2;

    always_comb begin
        state_next = state_cur;
        state_next.previous_byte = rx_byte;
        result.produced = 1'b0;
        result.data     = stored;
        result.position = state_cur.frame_index[6:0];
        result.last     = 1'b0;
        result.status   = efr_pkg::STATUS_GOOD;
        if (is_start) begin
            state_next.frame_index   = 8'd0;
            state_next.crc_remainder = crc_init;
        end else if (take) begin
            state_next.length_byte   = len_new;
            state_next.crc_remainder = crc_new;
            state_next.frame_index   = idx_inc;
            result.produced          = 1'b1;
            if (end_hit) begin
                result.last            = 1'b1;
                state_next.frame_index = efr_pkg::WAITING_INDEX;
                if (crc_new != 16'h0000) begin
                    result.status = efr_pkg::STATUS_CRC_ERR;
                end else if (payload_len >= max_payload) begin
                    result.status = efr_pkg::STATUS_TOO_LONG;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/escaped_frame_receiver.sv =====
// Top level of the escaped frame receiver: channels, input and result registers, settings.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                               Contents
// s_        in         s_tvalid s_tready s_tdata[7:0]        raw received byte
// m_        out        m_tvalid m_tready m_tdata[15:0]       decoded byte and its position
//                      m_tlast m_tuser[1:0]                  end of frame, frame status
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  settings writes
//
// A received byte is first held in the input register, then is decoded and its result
// (if any) lands in the result register. With m_tready high a new byte is taken in every
// cycle; the byte-wide CRC update and the end-of-frame compare lie on that combinational path.
// Reset (aresetn low, synchronous) empties both registers, puts the receiver back to
// waiting for a start byte and restores the settings to crc_init 0xFFFF, max_payload 255.
// When the result register is full and m_tready is low, the input register holds its byte
// and s_tready falls once it too is occupied.

module escaped_frame_receiver #(
    parameter int BUF_BYTES = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [7:0] data, [14:8] position, [15] zero
    output logic             m_tlast,    // last
    output logic [1:0]       m_tuser,    // [1:0] status

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [efr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Settings registers, written through their own channel at any time.
    logic [15:0] crc_init_reg;
    logic [7:0]  max_payload_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Receiver state.
    efr_pkg::efr_state_t state_reg;
    efr_pkg::efr_state_t state_next;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic [6:0]  out_pos_reg;
    logic        out_last_reg;
    efr_pkg::status_t out_status_reg;

    efr_pkg::efr_result_t result;

    logic advance;

    // The held byte moves on whenever the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    efr_decode #(
        .BUF_BYTES (BUF_BYTES)
    ) u_decode (
        .rx_byte     (in_byte_reg),
        .crc_init    (crc_init_reg),
        .max_payload (max_payload_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_init_reg    <= efr_pkg::CRC_INIT_RST;
            max_payload_reg <= efr_pkg::MAX_PAY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                efr_pkg::CFG_CRC_INIT:    crc_init_reg    <= cfg_data;
                efr_pkg::CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.frame_index   <= efr_pkg::WAITING_INDEX;
            state_reg.previous_byte <= 8'd0;
            state_reg.length_byte   <= 8'd0;
            state_reg.crc_remainder <= efr_pkg::CRC_INIT_RST;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // A transfer out frees the register; a produced result refills it in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.produced;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.produced) begin
            out_data_reg   <= result.data;
            out_pos_reg    <= result.position;
            out_last_reg   <= result.last;
            out_status_reg <= result.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_pos_reg, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ===== verif/escaped_frame_receiver_tb.sv =====
// Self-checking testbench for the escaped frame receiver: framed byte traffic and a scoreboard.
`timescale 1ns / 1ps

module escaped_frame_receiver_tb;

    // The buffer bound is kept at its default so that frames up to 128 stored bytes can end.
    localparam int BUF_BYTES      = 128;
    localparam int ITEMS          = 1300;
    localparam int NUM_PHASES     = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    // One decoded byte as the result channel should present it.
    typedef struct packed {
        logic [7:0]       data;
        logic [6:0]       position;
        logic             last;
        efr_pkg::status_t status;
    } rx_result_t;

    // How the result side paces its tready.
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_CRAWL
    } ready_mode_t;

    // The scoreboard keeps its own copy of the deframer state and settings. Every accepted raw
    // byte is run through the deframer here, and the decoded bytes it should yield wait in a
    // queue until the block presents them.
    class frame_scoreboard;
        logic [15:0] crc_seed;
        logic [7:0]  payload_limit;
        logic [7:0]  stored_count;
        logic [7:0]  prev_raw;
        logic [7:0]  len_field;
        logic [15:0] crc_rem;
        rx_result_t  decoded_q[$];
        int          errors;

        function new();
            crc_seed      = efr_pkg::CRC_INIT_RST;
            payload_limit = efr_pkg::MAX_PAY_RST;
            stored_count  = efr_pkg::WAITING_INDEX;
            prev_raw      = 8'h00;
            len_field     = 8'h00;
            crc_rem       = efr_pkg::CRC_INIT_RST;
            errors        = 0;
        endfunction

        // CRC-16-CCITT fed one bit at a time, most significant bit first.
        function logic [15:0] crc_next(logic [15:0] rem, logic [7:0] value);
            logic feedback;
            for (int k = 7; k >= 0; k--) begin
                feedback = rem[15] ^ value[k];
                rem = {rem[14:0], 1'b0};
                if (feedback) begin
                    rem = rem ^ efr_pkg::CRC_POLY;
                end
            end
            return rem;
        endfunction

        function void write_reg(logic [efr_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] value);
            if (idx == efr_pkg::CFG_CRC_INIT) begin
                crc_seed = value;
            end else if (idx == efr_pkg::CFG_MAX_PAYLOAD) begin
                payload_limit = value[7:0];
            end
        endfunction

        function void note_byte(logic [7:0] raw);
            logic [7:0] stored;
            logic [8:0] end_point;
            rx_result_t r;
            if (raw == efr_pkg::START_BYTE) begin
                stored_count = 8'd0;
                crc_rem      = crc_seed;
            end else if (raw != efr_pkg::ESC_BYTE && stored_count < BUF_BYTES) begin
                stored = (prev_raw == efr_pkg::ESC_BYTE) ? ~raw : raw;
                if (stored_count == efr_pkg::LENGTH_POS) begin
                    len_field = stored;
                end
                crc_rem    = crc_next(crc_rem, stored);
                r.data     = stored;
                r.position = stored_count[6:0];
                r.last     = 1'b0;
                r.status   = efr_pkg::STATUS_GOOD;
                stored_count = stored_count + 8'd1;
                end_point  = {1'b0, len_field} + efr_pkg::LEN_OFFSET;
                if ({1'b0, stored_count} == end_point) begin
                    r.last = 1'b1;
                    if (crc_rem != 16'h0000) begin
                        r.status = efr_pkg::STATUS_CRC_ERR;
                    end else if (stored_count - 8'd2 >= payload_limit) begin
                        r.status = efr_pkg::STATUS_TOO_LONG;
                    end
                    stored_count = efr_pkg::WAITING_INDEX;
                end
                decoded_q.push_back(r);
            end
            prev_raw = raw;
        endfunction

        function void check_result(logic [7:0] data, logic [6:0] pos, logic last,
                                   logic [1:0] st);
            rx_result_t want;
            bit bad;
            bad = 1'b0;
            if (decoded_q.size() == 0) begin
                $error("result with nothing expected: data %02h, position %0d", data, pos);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (data !== want.data) begin
                $error("data: expected %02h, actual %02h", want.data, data);
                bad = 1'b1;
            end
            if (pos !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, pos);
                bad = 1'b1;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                bad = 1'b1;
            end
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                bad = 1'b1;
            end
            if (bad) begin
                errors++;
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    // Every input of the block starts from a known value.
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic [7:0]                      s_tdata   = 8'h00;
    logic                            m_tready  = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [efr_pkg::CFG_INDEX_W-1:0] cfg_index = efr_pkg::CFG_CRC_INIT;
    logic [15:0]                     cfg_data  = 16'h0000;

    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [15:0] m_tdata;
    wire logic        m_tlast;
    wire logic [1:0]  m_tuser;
    wire logic        cfg_ready;

    frame_scoreboard sb;

    // Stored bytes of the frame that is about to go out, before stuffing.
    logic [7:0] frame_bytes[$];

    int          burst_left   = 0;
    int          bytes_sent   = 0;
    int          quiet_cycles = 0;
    int          ready_left   = 0;
    ready_mode_t ready_mode   = RDY_ALWAYS;

    logic [15:0] crc_plan   [NUM_PHASES];
    logic [7:0]  limit_plan [NUM_PHASES];

    escaped_frame_receiver #(
        .BUF_BYTES(BUF_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // All stimulus changes with nonblocking assignments at the rising edge, so at each edge
    // the handshake signals read here still hold the values they had just before it. A
    // result is checked before the byte accepted at the same edge is noted, since that byte
    // cannot have produced it yet.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata[7:0], m_tdata[14:8], m_tlast, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
            end
        end
    end

    // The result side switches between pacing modes, each held for a stretch of cycles: always
    // ready, a coin toss, mostly ready, and a crawl, ready when ready_left is a multiple of 20.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            case ($urandom_range(0, 3))
                0: ready_mode = RDY_ALWAYS;
                1: ready_mode = RDY_COIN;
                2: ready_mode = RDY_MOSTLY;
                default: ready_mode = RDY_CRAWL;
            endcase
            ready_left = $urandom_range(10, 120);
        end
        ready_left--;
        case (ready_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            default:    m_tready <= (ready_left % 20 == 0);
        endcase
    end

    // The watchdog ends the run once nothing has been transferred on any channel for too
    // long. The longest quiet stretch of a correct run is a receiver crawl or a sender gap,
    // both well under this limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One raw byte goes out as one transfer. The sender works in bursts: when a burst is
    // used up it may drop tvalid for a random gap before the next one starts. A byte that
    // follows a transfer straight away keeps tvalid high without lowering it.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    // The sender holds off until every decoded byte has been seen, then waits out the settle
    // period so that a start or escape byte still inside the block has been absorbed.
    task automatic drain_results();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both registers are written back to back while the block is idle. The scoreboard takes
    // each new value once its transfer has happened.
    task automatic apply_settings(input logic [15:0] crc_seed, input logic [7:0] limit);
        cfg_valid <= 1'b1;
        cfg_index <= efr_pkg::CFG_CRC_INIT;
        cfg_data  <= crc_seed;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(efr_pkg::CFG_CRC_INIT, crc_seed);
        cfg_index <= efr_pkg::CFG_MAX_PAYLOAD;
        cfg_data  <= {8'h00, limit};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(efr_pkg::CFG_MAX_PAYLOAD, {8'h00, limit});
        cfg_valid <= 1'b0;
    endtask

    // A frame holds its length field as the fourth stored byte and ends after that value
    // plus six stored bytes. A length too large for the buffer gives a run of bytes that
    // fills the buffer and never ends.
    function automatic void build_frame(input int len_val);
        int total;
        logic [7:0] rb;
        frame_bytes.delete();
        total = len_val + 6;
        if (total > BUF_BYTES) begin
            total = BUF_BYTES + $urandom_range(1, 4);
        end
        for (int i = 0; i < total; i++) begin
            rb = 8'($urandom_range(0, 255));
            frame_bytes.push_back(rb);
        end
        frame_bytes[3] = len_val[7:0];
    endfunction

    // The last two bytes carry the CRC, high byte first, so that the remainder over the whole
    // frame comes out zero. A corrupted frame gets one flipped bit anywhere but in the
    // length field, which keeps its end where it was.
    function automatic void seal_frame(input bit corrupt);
        logic [15:0] rem;
        int n;
        int idx;
        n   = frame_bytes.size();
        rem = sb.crc_seed;
        for (int i = 0; i < n - 2; i++) begin
            rem = sb.crc_next(rem, frame_bytes[i]);
        end
        frame_bytes[n-2] = rem[15:8];
        frame_bytes[n-1] = rem[7:0];
        if (corrupt) begin
            idx = $urandom_range(0, n - 2);
            if (idx >= 3) begin
                idx++;
            end
            frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
    endfunction

    // Sends an optional escape, a start byte and the first keep stored bytes of the frame,
    // stuffed. Start and escape values always go out escaped, other bytes by chance; an escape
    // may be doubled. A byte whose complement is a start or escape value cannot be escaped.
    task automatic send_frame(input int keep, input int esc_pct, input int dbl_pct,
                              input bit pre_esc);
        logic [7:0] b;
        if (pre_esc) begin
            send_byte(efr_pkg::ESC_BYTE);
        end
        send_byte(efr_pkg::START_BYTE);
        for (int i = 0; i < keep; i++) begin
            b = frame_bytes[i];
            if (b == efr_pkg::START_BYTE || b == efr_pkg::ESC_BYTE ||
                (b != ~efr_pkg::START_BYTE && b != ~efr_pkg::ESC_BYTE &&
                 $urandom_range(0, 99) < esc_pct)) begin
                if ($urandom_range(0, 99) < dbl_pct) begin
                    send_byte(efr_pkg::ESC_BYTE);
                end
                send_byte(efr_pkg::ESC_BYTE);
                send_byte(~b);
            end else begin
                send_byte(b);
            end
        end
    endtask

    task automatic directed_frames();
        // Bytes outside any frame are dropped.
        send_byte(8'h00);
        send_byte(8'hFF);
        // A shortest frame opened by an escape followed by a start byte, with start and
        // escape values in its header and every byte escaped that can be.
        build_frame(0);
        frame_bytes[0] = efr_pkg::START_BYTE;
        frame_bytes[1] = efr_pkg::ESC_BYTE;
        frame_bytes[2] = 8'h00;
        seal_frame(1'b0);
        send_frame(frame_bytes.size(), 100, 0, 1'b1);
        // A frame cut short by a new start byte, with doubled escapes.
        build_frame(0);
        seal_frame(1'b0);
        send_frame(2, 100, 100, 1'b0);
        // A shortest frame with a broken CRC.
        build_frame(0);
        seal_frame(1'b1);
        send_frame(frame_bytes.size(), 0, 0, 1'b0);
    endtask

    // Mostly well-formed frames with random content and small lengths. Some carry a broken
    // CRC, some are cut short by the next start, a few are the largest that fit or too long
    // for the buffer, and stray bytes fall between frames now and then.
    task automatic random_traffic(input int phase, input int quota);
        int start_count;
        int len_val;
        int sel;
        int keep;
        bit first;
        start_count = bytes_sent;
        first = 1'b1;
        while (bytes_sent - start_count < quota) begin
            sel = $urandom_range(0, 99);
            if (first && phase == 2) begin
                len_val = BUF_BYTES - 6;
            end else if (first && phase == 5) begin
                len_val = $urandom_range(BUF_BYTES - 5, 255);
            end else if (sel < 2) begin
                len_val = BUF_BYTES - 6;
            end else if (sel < 4) begin
                len_val = $urandom_range(BUF_BYTES - 5, 255);
            end else if (sel < 14) begin
                len_val = $urandom_range(13, 60);
            end else begin
                len_val = $urandom_range(0, 12);
            end
            first = 1'b0;
            build_frame(len_val);
            seal_frame($urandom_range(0, 99) < 15);
            keep = frame_bytes.size();
            if ($urandom_range(0, 99) < 10) begin
                keep = $urandom_range(0, keep - 1);
            end
            send_frame(keep, $urandom_range(0, 30), 10, $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 49) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        int p;
        sb = new();

        // Each phase runs under its own settings; the first keeps the values from reset.
        crc_plan[0] = efr_pkg::CRC_INIT_RST;  limit_plan[0] = efr_pkg::MAX_PAY_RST;
        crc_plan[1] = 16'h0000;               limit_plan[1] = 8'd0;
        crc_plan[2] = 16'hFFFF;               limit_plan[2] = 8'd255;
        crc_plan[3] = 16'h1D0F;               limit_plan[3] = 8'd12;
        crc_plan[4] = 16'($urandom);          limit_plan[4] = 8'd1;
        crc_plan[5] = 16'h0000;               limit_plan[5] = 8'd255;
        crc_plan[6] = 16'($urandom);          limit_plan[6] = 8'd8;
        crc_plan[7] = 16'($urandom);          limit_plan[7] = 8'($urandom_range(0, 255));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == 0) begin
                directed_frames();
            end else begin
                drain_results();
                apply_settings(crc_plan[p], limit_plan[p]);
            end
            random_traffic(p, ITEMS / NUM_PHASES);
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/efr_pkg.sv
hdl/efr_decode.sv
hdl/escaped_frame_receiver.sv
verif/escaped_frame_receiver_tb.sv
